// ----- design/gdds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date day stepper package
// Shared types, codes, calendar helpers and the control store of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
package gdds_pkg;

    // Field widths of the stream payloads.
    localparam int REQ_W     = 2;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_F_W  = 12;
    localparam int COUNT_F_W = 16;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    // Parameter defaults.
    localparam int DEFAULT_MAX_YEAR    = 4095;
    localparam int DEFAULT_COUNT_WIDTH = 16;

    // Calendar constants.
    localparam int BASE_YEAR = 1900;
    localparam int LEAP_W    = 16;
    // Reciprocal of 25 scaled by 2^21; exact floor for any 16-bit year.
    localparam int RECIP_25  = 83887;
    localparam int RECIP_SH  = 21;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;

    // Request kinds carried in tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_SET = 2'd0,
        REQ_ADD = 2'd1,
        REQ_SUB = 2'd2,
        REQ_NOP = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_CLAMPED   = 2'd2,
        STAT_SATURATED = 2'd3
    } status_t;

    // Step counter values of the sequencer.
    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_SET_LEAP,
        STEP_SET,
        STEP_ADD_CHK,
        STEP_ADD_ADV,
        STEP_ADD_FIN,
        STEP_SUB_CHK,
        STEP_SUB_ADV,
        STEP_SUB_FIN,
        STEP_DONE
    } step_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LEAP,
        OP_SET,
        OP_ADD_ADV,
        OP_ADD_FIN,
        OP_SUB_ADV,
        OP_SUB_FIN,
        OP_OUT
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_FIT_ADD,
        COND_FIT_SUB,
        COND_AT_TOP,
        COND_AT_BOT,
        COND_OUT_FREE
    } cond_t;

    // One control word: operation, condition, taken target, fallback target.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        step_t alt;
    } uword_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic fit_add;
        logic fit_sub;
        logic at_top;
        logic at_bot;
    } dp_flags_t;

    // Leap year by the 4/100/400 rule, with mod 25 by reciprocal multiply.
    function automatic logic is_leap(input logic [LEAP_W-1:0] y);
        logic [32:0]       prod;
        logic [11:0]       quo;
        logic [LEAP_W-1:0] rem25;
        prod  = 33'(y) * 33'(RECIP_25);
        quo   = prod[RECIP_SH+11:RECIP_SH];
        rem25 = y - LEAP_W'(LEAP_W'(quo) * LEAP_W'(25));
        return (y[1:0] == 2'd0) && ((rem25 != '0) || (y[3:0] == 4'd0));
    endfunction

    // Length of a month; codes outside 1..12 read as 31.
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MON_FEB:                            len = leap ? DAYS_29 : DAYS_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
            default:                            len = DAYS_31;
        endcase
        return len;
    endfunction

    // Control store of the sequencer.
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        unique case (s)
            STEP_IDLE:     w = '{OP_LOAD,    COND_DISPATCH, STEP_IDLE,    STEP_IDLE};
            STEP_SET_LEAP: w = '{OP_LEAP,    COND_ALWAYS,   STEP_SET,     STEP_SET};
            STEP_SET:      w = '{OP_SET,     COND_ALWAYS,   STEP_DONE,    STEP_DONE};
            STEP_ADD_CHK:  w = '{OP_NONE,    COND_FIT_ADD,  STEP_ADD_FIN, STEP_ADD_ADV};
            STEP_ADD_ADV:  w = '{OP_ADD_ADV, COND_AT_TOP,   STEP_DONE,    STEP_ADD_CHK};
            STEP_ADD_FIN:  w = '{OP_ADD_FIN, COND_ALWAYS,   STEP_DONE,    STEP_DONE};
            STEP_SUB_CHK:  w = '{OP_NONE,    COND_FIT_SUB,  STEP_SUB_FIN, STEP_SUB_ADV};
            STEP_SUB_ADV:  w = '{OP_SUB_ADV, COND_AT_BOT,   STEP_DONE,    STEP_SUB_CHK};
            STEP_SUB_FIN:  w = '{OP_SUB_FIN, COND_ALWAYS,   STEP_DONE,    STEP_DONE};
            STEP_DONE:     w = '{OP_OUT,     COND_OUT_FREE, STEP_IDLE,    STEP_DONE};
            default:       w = '{OP_NONE,    COND_ALWAYS,   STEP_IDLE,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- design/gdds_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date stepper datapath
// Holds the current date, the remaining day count and the latched request,
// and executes one operation per cycle as selected by the sequencer.
// ----------------------------------------------------------------------------
module gdds_datapath
    import gdds_pkg::*;
#(
    parameter int MAX_YEAR    = DEFAULT_MAX_YEAR,
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  op_t                   op,
    input  logic [DAY_W-1:0]      in_day,
    input  logic [MONTH_W-1:0]    in_month,
    input  logic [YEAR_F_W-1:0]   in_year,
    input  logic [COUNT_F_W-1:0]  in_count,
    output dp_flags_t             flags,
    output logic [DAY_W-1:0]      cur_day,
    output logic [MONTH_W-1:0]    cur_month,
    output logic [YEAR_F_W-1:0]   cur_year,
    output status_t               status
);

    localparam int YEAR_W = $clog2(MAX_YEAR + 1);
    localparam int REM_W  = (COUNT_WIDTH > DAY_W) ? COUNT_WIDTH : DAY_W;
    localparam logic [COUNT_F_W-1:0] CNT_MASK = (COUNT_WIDTH >= COUNT_F_W) ?
        {COUNT_F_W{1'b1}} : COUNT_F_W'((32'd1 << COUNT_WIDTH) - 32'd1);
    localparam logic [YEAR_W-1:0] TOP_YEAR = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] BOT_YEAR = YEAR_W'(BASE_YEAR);

    logic [DAY_W-1:0]    day_reg,   day_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg,  year_next;
    status_t             status_reg, status_next;
    logic [REM_W-1:0]    rem_reg,   rem_next;
    logic                leap_reg;
    logic                leap_new_reg;
    logic [DAY_W-1:0]    nd_reg;
    logic [MONTH_W-1:0]  nm_reg;
    logic [YEAR_F_W-1:0] ny_reg;

    logic [DAY_W-1:0]    dim;
    logic [DAY_W-1:0]    day_left;
    logic [DAY_W-1:0]    prev_dim;
    logic                set_ok;

    // Month length and distance to the end of the month.
    assign dim      = days_in(month_reg, leap_reg);
    assign day_left = dim - day_reg;
    assign prev_dim = days_in(month_reg - MONTH_W'(1), leap_reg);

    assign flags.fit_add = (rem_reg <= REM_W'(day_left));
    assign flags.fit_sub = (rem_reg < REM_W'(day_reg));
    assign flags.at_top  = (month_reg == MON_DEC) && (year_reg == TOP_YEAR);
    assign flags.at_bot  = (month_reg == MON_JAN) && (year_reg == BOT_YEAR);

    // Validity of the latched date for a set request.
    assign set_ok = (nm_reg >= MON_JAN) && (nm_reg <= MON_DEC) && (nd_reg != '0) &&
                    (ny_reg >= YEAR_F_W'(BASE_YEAR)) &&
                    (17'(ny_reg) <= 17'(MAX_YEAR)) &&
                    (nd_reg <= days_in(nm_reg, leap_new_reg));

    // Operation decoder.
    always_comb begin
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        unique case (op)
            OP_LOAD: begin
                status_next = STAT_OK;
                rem_next    = REM_W'(in_count & CNT_MASK);
            end
            OP_SET: begin
                if (set_ok) begin
                    day_next   = nd_reg;
                    month_next = nm_reg;
                    year_next  = YEAR_W'(ny_reg);
                end else begin
                    status_next = STAT_INVALID;
                end
            end
            OP_ADD_ADV: begin
                rem_next = rem_reg - (REM_W'(day_left) + REM_W'(1));
                if (flags.at_top) begin
                    day_next    = DAYS_31;
                    status_next = STAT_SATURATED;
                end else if (month_reg == MON_DEC) begin
                    month_next = MON_JAN;
                    year_next  = year_reg + YEAR_W'(1);
                    day_next   = DAY_W'(1);
                end else begin
                    month_next = month_reg + MONTH_W'(1);
                    day_next   = DAY_W'(1);
                end
            end
            OP_ADD_FIN: day_next = day_reg + rem_reg[DAY_W-1:0];
            OP_SUB_ADV: begin
                rem_next = rem_reg - REM_W'(day_reg);
                if (flags.at_bot) begin
                    day_next    = DAY_W'(1);
                    status_next = STAT_CLAMPED;
                end else if (month_reg == MON_JAN) begin
                    month_next = MON_DEC;
                    year_next  = year_reg - YEAR_W'(1);
                    day_next   = DAYS_31;
                end else begin
                    month_next = month_reg - MONTH_W'(1);
                    day_next   = prev_dim;
                end
            end
            OP_SUB_FIN: day_next = day_reg - rem_reg[DAY_W-1:0];
            OP_NONE, OP_LEAP, OP_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Date and status state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg    <= DAY_W'(1);
            month_reg  <= MON_JAN;
            year_reg   <= BOT_YEAR;
            status_reg <= STAT_OK;
            leap_reg   <= 1'b0;
        end else begin
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            status_reg <= status_next;
            // Registered from the year, so it lags it; February is never reached before it catches up.
            leap_reg   <= is_leap(LEAP_W'(year_reg));
        end
    end

    // Request payload and remaining count.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (op == OP_LOAD) begin
            nd_reg <= in_day;
            nm_reg <= in_month;
            ny_reg <= in_year;
        end
        if (op == OP_LEAP) begin
            leap_new_reg <= is_leap(LEAP_W'(ny_reg));
        end
    end

    assign cur_day   = day_reg;
    assign cur_month = month_reg;
    assign cur_year  = year_reg[YEAR_F_W-1:0];
    assign status    = status_reg;

endmodule

// ----- design/gregorian_date_day_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date day stepper
// Holds a date and serves set, add-days and subtract-days requests.
// ----------------------------------------------------------------------------
// The block holds one Gregorian date, reset to 1/1/1900, and takes one request
// per input transaction: set a date (rejected with status 1 if invalid), add
// a day count (saturating at 31/12/MAX_YEAR with status 3) or subtract a day
// count (clamping at 1/1/1900 with status 2); each request returns exactly one
// result transaction holding the date and a status. A microcoded sequencer
// walks the date one month per pass through its check and advance steps. An
// add or subtract makes one pass per month boundary crossed, then a finish
// step unless it saturates or clamps; a set runs a leap step and a set step;
// request code 3 skips straight to the last step, which loads the result into
// the output register and, while that register still holds an untaken result,
// waits. One request is in flight at a time; the next is accepted while the
// previous result still waits in the output register.
module gregorian_date_day_stepper
    import gdds_pkg::*;
#(
    parameter int MAX_YEAR    = DEFAULT_MAX_YEAR,
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // new_day[4:0], new_month[8:5], new_year[20:9], day_count[36:21], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // cur_day[4:0], cur_month[8:5], cur_year[20:9], status[22:21], zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    step_t               step_reg, step_next;
    uword_t              uword;
    op_t                 dp_op;
    dp_flags_t           flags;
    logic                out_free;
    logic                out_load;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [DAY_W-1:0]    cur_day;
    logic [MONTH_W-1:0]  cur_month;
    logic [YEAR_F_W-1:0] cur_year;
    status_t             status;

    assign uword    = ucode_rom(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Next step: dispatch on the request kind or a conditional jump.
    always_comb begin
        step_next = uword.alt;
        case (uword.cond)
            COND_DISPATCH: begin
                if (s_tvalid) begin
                    unique case (req_t'(s_tuser))
                        REQ_SET: step_next = STEP_SET_LEAP;
                        REQ_ADD: step_next = STEP_ADD_CHK;
                        REQ_SUB: step_next = STEP_SUB_CHK;
                        REQ_NOP: step_next = STEP_DONE;
                        default: step_next = STEP_IDLE;
                    endcase
                end
            end
            COND_ALWAYS:   step_next = uword.target;
            COND_FIT_ADD:  if (flags.fit_add) step_next = uword.target;
            COND_FIT_SUB:  if (flags.fit_sub) step_next = uword.target;
            COND_AT_TOP:   if (flags.at_top)  step_next = uword.target;
            COND_AT_BOT:   if (flags.at_bot)  step_next = uword.target;
            COND_OUT_FREE: if (out_free)      step_next = uword.target;
            default:       step_next = STEP_IDLE;
        endcase
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // Control outputs of the current step.
    always_comb begin
        s_tready = (uword.op == OP_LOAD);
        out_load = (uword.op == OP_OUT) && out_free;
        dp_op    = uword.op;
        if ((uword.op == OP_LOAD) && !s_tvalid) begin
            dp_op = OP_NONE;
        end
    end

    gdds_datapath #(
        .MAX_YEAR    (MAX_YEAR),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (dp_op),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[20:9]),
        .in_count  (s_tdata[36:21]),
        .flags     (flags),
        .cur_day   (cur_day),
        .cur_month (cur_month),
        .cur_year  (cur_year),
        .status    (status)
    );

    // Output register: holds a result until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, status, cur_year, cur_month, cur_day};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/tb_gregorian_date_day_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date day stepper testbench
// Drives set, add-days, subtract-days and unused requests into the stepper.
// A scoreboard tracks the held date with its own day-number arithmetic and
// checks every result transaction field by field. The sender pauses in bursts
// and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_gregorian_date_day_stepper;
    import gdds_pkg::*;

    localparam int TOP_YEAR   = DEFAULT_MAX_YEAR;
    localparam int CNT_BITS   = DEFAULT_COUNT_WIDTH;
    localparam int RAND_ITEMS = 950;

    // Receiver stall patterns.
    typedef enum int {
        SINK_OPEN,
        SINK_BUSY,
        SINK_CHOKED
    } sink_mode_t;

    // One expected result transaction.
    typedef struct {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_F_W-1:0] year;
        status_t             status;
    } date_word_t;

    // Scoreboard: tracks the held date and compares result transactions.
    class date_tracker;
        int unsigned held_day;
        int unsigned held_month;
        int unsigned held_year;
        date_word_t  expected_dates[$];
        int          error_count;

        function new();
            held_day    = 1;
            held_month  = 1;
            held_year   = BASE_YEAR;
            error_count = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int unsigned month_length(int unsigned m, int unsigned y);
            if (m == MON_FEB)
                return leap_year(y) ? 29 : 28;
            if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
                return 30;
            return 31;
        endfunction

        static function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
            if (m < 1 || m > 12 || d < 1)
                return 1'b0;
            if (y < BASE_YEAR || y > TOP_YEAR)
                return 1'b0;
            return d <= month_length(m, y);
        endfunction

        // Serial day number; years are counted from March so that the leap
        // day falls at the end of the year.
        static function longint unsigned day_number(int unsigned d, int unsigned m,
                                                    int unsigned y);
            longint unsigned shifted_year;
            longint unsigned cycle;
            longint unsigned year_in_cycle;
            longint unsigned march_month;
            longint unsigned day_in_year;
            shifted_year  = 64'(y - ((m <= 2) ? 1 : 0));
            cycle         = shifted_year / 400;
            year_in_cycle = shifted_year - cycle * 400;
            march_month   = 64'((m > 2) ? m - 3 : m + 9);
            day_in_year   = (153 * march_month + 2) / 5 + d - 1;
            return cycle * 146097 + year_in_cycle * 365 + year_in_cycle / 4
                   - year_in_cycle / 100 + day_in_year;
        endfunction

        // Converts a serial day number back into the held date.
        function void load_day_number(longint unsigned z);
            longint unsigned cycle;
            longint unsigned day_in_cycle;
            longint unsigned year_in_cycle;
            longint unsigned day_in_year;
            longint unsigned march_month;
            cycle         = z / 146097;
            day_in_cycle  = z - cycle * 146097;
            year_in_cycle = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                             - day_in_cycle / 146096) / 365;
            day_in_year   = day_in_cycle - (365 * year_in_cycle + year_in_cycle / 4
                                            - year_in_cycle / 100);
            march_month   = (5 * day_in_year + 2) / 153;
            held_day      = 32'(day_in_year - (153 * march_month + 2) / 5 + 1);
            held_month    = 32'((march_month < 10) ? march_month + 3 : march_month - 9);
            held_year     = 32'(year_in_cycle + cycle * 400 + ((held_month <= 2) ? 1 : 0));
        endfunction

        // Applies one request to the held date and returns the status.
        function status_t step_date(req_t req, int unsigned d, int unsigned m,
                                    int unsigned y, longint unsigned cnt);
            longint unsigned now_num;
            longint unsigned top_num;
            longint unsigned base_num;
            status_t         st;
            st       = STAT_OK;
            now_num  = day_number(held_day, held_month, held_year);
            top_num  = day_number(31, 12, TOP_YEAR);
            base_num = day_number(1, 1, BASE_YEAR);
            case (req)
                REQ_SET: begin
                    if (date_ok(d, m, y)) begin
                        held_day   = d;
                        held_month = m;
                        held_year  = y;
                    end else begin
                        st = STAT_INVALID;
                    end
                end
                REQ_ADD: begin
                    if (cnt > top_num - now_num) begin
                        load_day_number(top_num);
                        st = STAT_SATURATED;
                    end else begin
                        load_day_number(now_num + cnt);
                    end
                end
                REQ_SUB: begin
                    if (cnt > now_num - base_num) begin
                        load_day_number(base_num);
                        st = STAT_CLAMPED;
                    end else begin
                        load_day_number(now_num - cnt);
                    end
                end
                default: ;
            endcase
            return st;
        endfunction

        // Records an accepted request and queues the date it leads to.
        function void note_request(req_t req, logic [S_DATA_W-1:0] word);
            date_word_t      exp_word;
            longint unsigned cnt;
            cnt             = word[36:21] & ((64'd1 << CNT_BITS) - 1);
            exp_word.status = step_date(req, 32'(word[4:0]), 32'(word[8:5]),
                                        32'(word[20:9]), cnt);
            exp_word.day    = DAY_W'(held_day);
            exp_word.month  = MONTH_W'(held_month);
            exp_word.year   = YEAR_F_W'(held_year);
            expected_dates.push_back(exp_word);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
                         want, got);
                error_count++;
            end
        endfunction

        // Checks a result transaction against the oldest expected date.
        function void check_result(logic [M_DATA_W-1:0] word);
            date_word_t exp_word;
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, word);
                error_count++;
                return;
            end
            exp_word = expected_dates.pop_front();
            compare_field("cur_day", 32'(exp_word.day), 32'(word[4:0]));
            compare_field("cur_month", 32'(exp_word.month), 32'(word[8:5]));
            compare_field("cur_year", 32'(exp_word.year), 32'(word[20:9]));
            compare_field("status", 32'(exp_word.status), 32'(word[22:21]));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    date_tracker board = new();
    int          burst_left = 0;

    gregorian_date_day_stepper uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Both channels are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_request(req_t'(s_tuser), s_tdata);
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Receiver: picks a random stall pattern and holds it for a random time.
    initial begin : receiver
        sink_mode_t mode;
        int         hold;
        m_tready = 1'b0;
        forever begin
            mode = sink_mode_t'($urandom_range(0, 2));
            hold = $urandom_range(16, 160);
            repeat (hold) begin
                @(negedge aclk);
                case (mode)
                    SINK_OPEN: m_tready <= 1'b1;
                    SINK_BUSY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Sends one request transaction, with a random gap between bursts.
    task automatic send_item(input req_t req, input logic [DAY_W-1:0] d,
                             input logic [MONTH_W-1:0] m, input logic [YEAR_F_W-1:0] y,
                             input logic [COUNT_F_W-1:0] cnt);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, cnt, y, m, d};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Day counts: mostly short steps, a few spanning many years.
    function automatic logic [COUNT_F_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return COUNT_F_W'($urandom_range(0, 62));
        if (sel < 90)
            return COUNT_F_W'($urandom_range(0, 800));
        if (sel < 96)
            return COUNT_F_W'($urandom_range(0, 8191));
        return COUNT_F_W'($urandom_range(0, 65535));
    endfunction

    initial begin : stimulus
        int                   pick;
        int unsigned          yr;
        int unsigned          mo;
        logic [COUNT_F_W-1:0] cnt;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_NOP;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests: reset date, clamping, leap rules, invalid dates,
        // and saturation at the last supported day.
        send_item(REQ_NOP, 0, 0, 0, 0);
        send_item(REQ_SUB, 0, 0, 0, 1);
        send_item(REQ_SUB, 0, 0, 0, 0);
        send_item(REQ_ADD, 0, 0, 0, 0);
        send_item(REQ_ADD, 0, 0, 0, 16'hFFFF);
        send_item(REQ_SET, 29, 2, 1900, 0);
        send_item(REQ_SET, 29, 2, 2000, 0);
        send_item(REQ_ADD, 0, 0, 0, 1);
        send_item(REQ_SUB, 0, 0, 0, 1);
        send_item(REQ_SET, 29, 2, 2100, 0);
        send_item(REQ_SET, 29, 2, 2004, 0);
        send_item(REQ_SET, 29, 2, 2001, 0);
        send_item(REQ_SET, 0, 5, 2000, 0);
        send_item(REQ_SET, 31, 4, 2000, 0);
        send_item(REQ_SET, 1, 0, 2000, 0);
        send_item(REQ_SET, 1, 13, 2000, 0);
        send_item(REQ_SET, 31, 15, 4095, 16'hFFFF);
        send_item(REQ_SET, 1, 1, 1899, 0);
        send_item(REQ_SET, 1, 1, 0, 0);
        send_item(REQ_SET, 31, 12, YEAR_F_W'(TOP_YEAR), 0);
        send_item(REQ_ADD, 0, 0, 0, 1);
        send_item(REQ_SUB, 0, 0, 0, 16'hFFFF);
        send_item(REQ_SET, 31, 12, 1999, 0);
        send_item(REQ_ADD, 0, 0, 0, 1);
        send_item(REQ_SUB, 0, 0, 0, 16'hFFFF);

        // Random requests: valid dates near both ends of the range keep the
        // clamp and saturation paths busy; raw fields supply malformed sets.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            cnt  = pick_count();
            if (pick < 19) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    yr = $urandom_range(BASE_YEAR, BASE_YEAR + 10);
                else if (pick < 7)
                    yr = $urandom_range(TOP_YEAR - 10, TOP_YEAR);
                else
                    yr = $urandom_range(BASE_YEAR, TOP_YEAR);
                mo = $urandom_range(1, 12);
                send_item(REQ_SET,
                          DAY_W'($urandom_range(1, date_tracker::month_length(mo, yr))),
                          MONTH_W'(mo), YEAR_F_W'(yr), cnt);
            end else if (pick < 25) begin
                send_item(REQ_SET, DAY_W'($urandom_range(0, 31)),
                          MONTH_W'($urandom_range(0, 15)),
                          YEAR_F_W'($urandom_range(0, 4095)),
                          COUNT_F_W'($urandom_range(0, 65535)));
            end else if (pick < 62) begin
                send_item(REQ_ADD, DAY_W'($urandom_range(0, 31)),
                          MONTH_W'($urandom_range(0, 15)),
                          YEAR_F_W'($urandom_range(0, 4095)), cnt);
            end else if (pick < 96) begin
                send_item(REQ_SUB, DAY_W'($urandom_range(0, 31)),
                          MONTH_W'($urandom_range(0, 15)),
                          YEAR_F_W'($urandom_range(0, 4095)), cnt);
            end else begin
                send_item(REQ_NOP, DAY_W'($urandom_range(0, 31)),
                          MONTH_W'($urandom_range(0, 15)),
                          YEAR_F_W'($urandom_range(0, 4095)), cnt);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain the results, then keep waiting for any stray one before the verdict.
        while (board.expected_dates.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.error_count == 0)
            $display("gregorian_date_day_stepper test passed");
        else
            $display("gregorian_date_day_stepper test failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #200_000_000;
        $display("gregorian_date_day_stepper test failed");
        $finish;
    end

endmodule
